/* rtl/ntpr_pkg.sv */
// Shared types, codes and conversion constants for the NTP request responder.
`default_nettype none

package ntpr_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STRATUM     = 3'd0,
    CFG_ROOT_DISP   = 3'd1,
    CFG_TIME_SOURCE = 3'd2,
    CFG_REF_EPOCH   = 3'd3,
    CFG_RATE_LIMIT  = 3'd4
  } cfg_idx_t;

  // Result action codes
  typedef enum logic [2:0] {
    ACT_SERVED      = 3'd0,
    ACT_RATE_KISS   = 3'd1,
    ACT_DROP_SHORT  = 3'd2,
    ACT_DROP_UNSYNC = 3'd3,
    ACT_DROP_MODE   = 3'd4
  } action_t;

  // Reference source codes; the unused code behaves like SRC_OTHER
  typedef enum logic [1:0] {
    SRC_OTHER    = 2'd0,
    SRC_NETWORK  = 2'd1,
    SRC_CELLULAR = 2'd2
  } time_source_t;

  // Window update request from the pipeline to the rate window
  localparam int WIN_SEC_W = 23;
  localparam int WIN_CNT_W = 16;

  typedef struct packed {
    logic                 upd;
    logic [WIN_SEC_W-1:0] sec;
  } win_req_t;

  // Packet field constants
  localparam logic [31:0] NTP_UNIX_OFFSET  = 32'd2208988800;
  localparam logic [15:0] MIN_REQ_LEN      = 16'd48;
  localparam logic [2:0]  MODE_CLIENT      = 3'd3;
  localparam logic [2:0]  MODE_SERVER      = 3'd4;
  localparam logic [2:0]  VN_MIN           = 3'd3;
  localparam logic [2:0]  VN_MAX           = 3'd4;
  localparam logic [1:0]  LEAP_NONE        = 2'b00;
  localparam logic [1:0]  LEAP_ALARM       = 2'b11;
  localparam logic [7:0]  POLL_BYTE        = 8'd6;
  localparam logic [7:0]  PRECISION_BYTE   = 8'hEC;
  localparam logic [31:0] REFID_GPS_DOT    = 32'h4750532E;
  localparam logic [31:0] REFID_DOT_GPS    = 32'h2E475053;
  localparam logic [31:0] REFID_DOT_LOC    = 32'h2E4C4F43;
  localparam logic [31:0] REFID_RATE       = 32'h52415445;
  localparam logic [WIN_CNT_W-1:0] COUNT_MAX        = '1;
  localparam logic [15:0]          RATE_LIMIT_RESET = 16'd20;

  // Reciprocals for constant division (rounded up, exact over the input range)
  localparam logic [38:0] P38 = 39'd1 << 38;
  localparam logic [36:0] P36 = 37'd1 << 36;
  localparam logic [52:0] P52 = 53'd1 << 52;
  localparam logic [56:0] P56 = 57'd1 << 56;
  localparam logic [66:0] P66 = 67'd1 << 66;

  // tick / 1000 = (tick * TICK_RECIP) >> 38
  localparam logic [28:0] TICK_RECIP    = 29'((P38 + 39'd999) / 39'd1000);
  // micros * 2^32 / 1e6 = (micros * MICRO_RECIP) >> 34
  localparam logic [46:0] MICRO_RECIP   = 47'((P66 + 67'd999999) / 67'd1000000);
  // ms * 2^16 / 1000 = (ms * DISP_RECIP) >> 23
  localparam logic [29:0] DISP_RECIP    = 30'((P36 + 37'd124) / 37'd125);
  // x / 125 = (x * EPOCH_RECIP) >> 52, x below 2^45
  localparam logic [45:0] EPOCH_RECIP   = 46'((P52 + 53'd124) / 53'd125);
  // ms_rem * 2^32 / 1000 = (ms_rem * FRAC_MS_RECIP) >> 24
  localparam logic [46:0] FRAC_MS_RECIP = 47'((P56 + 57'd999) / 57'd1000);

endpackage

`default_nettype wire

/* rtl/ntpr_epoch_conv.sv */
// Converts the last-sync time in Unix milliseconds to an NTP timestamp over three stages.
`default_nettype none

module ntpr_epoch_conv (
  input  wire logic        clk,
  input  wire logic [47:0] epoch_ms,
  output logic      [63:0] ref_ntp
);
  import ntpr_pkg::*;

  logic [44:0] x;
  logic [45:0] pp_ll_r;
  logic [45:0] pp_lh_r;
  logic [44:0] pp_hl_r;
  logic [44:0] pp_hh_r;
  logic [2:0]  m3_1_r;
  logic [90:0] sum;
  logic [31:0] q_r;
  logic [51:0] f_r;
  logic [2:0]  m3_2_r;
  logic [58:0] f125;
  logic [9:0]  rem_r;
  logic [31:0] sec_r;
  logic [56:0] frac_prod;

  // ms / 1000 = (ms >> 3) / 125, low three bits kept for the remainder
  assign x = epoch_ms[47:3];

  // Stage 1: partial products of x * EPOCH_RECIP
  always_ff @(posedge clk) begin
    pp_ll_r <= 46'(x[22:0])  * 46'(EPOCH_RECIP[22:0]);
    pp_lh_r <= 46'(x[22:0])  * 46'(EPOCH_RECIP[45:23]);
    pp_hl_r <= 45'(x[44:23]) * 45'(EPOCH_RECIP[22:0]);
    pp_hh_r <= 45'(x[44:23]) * 45'(EPOCH_RECIP[45:23]);
    m3_1_r  <= epoch_ms[2:0];
  end

  // Stage 2: sum partial products; integer part is the quotient, low bits the fraction
  assign sum = (91'(pp_hh_r) << 46) + ((91'(pp_lh_r) + 91'(pp_hl_r)) << 23) + 91'(pp_ll_r);

  always_ff @(posedge clk) begin
    q_r    <= sum[83:52];
    f_r    <= sum[51:0];
    m3_2_r <= m3_1_r;
  end

  // Stage 3: recover x mod 125 from the fraction, rebuild ms mod 1000, shift epoch
  assign f125 = {f_r, 7'b0} - {6'b0, f_r, 1'b0} - {7'b0, f_r};

  always_ff @(posedge clk) begin
    rem_r <= {f125[58:52], m3_2_r};
    sec_r <= q_r + NTP_UNIX_OFFSET;
  end

  // Scale the millisecond remainder to a 2^-32 fraction
  assign frac_prod = 57'(rem_r) * 57'(FRAC_MS_RECIP);
  assign ref_ntp   = {sec_r, frac_prod[55:24]};

endmodule

`default_nettype wire

/* rtl/ntpr_rate_window.sv */
// One-second request window with saturating count and over-budget flag.
`default_nettype none

module ntpr_rate_window (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ntpr_pkg::win_req_t  req,
  input  wire logic [15:0]         rate_limit,
  output logic                     over
);
  import ntpr_pkg::*;

  logic [WIN_SEC_W-1:0] win_sec_r;
  logic [WIN_CNT_W-1:0] win_cnt_r;
  logic [WIN_CNT_W-1:0] base_cnt;
  logic [WIN_CNT_W-1:0] win_cnt_nxt;

  // Restart the count on a new second, then saturate at the top
  assign base_cnt    = (req.sec == win_sec_r) ? win_cnt_r : '0;
  assign win_cnt_nxt = (base_cnt == COUNT_MAX) ? base_cnt : base_cnt + 1'b1;
  assign over        = win_cnt_nxt > rate_limit;

  // Advance window state only for requests that pass the drop checks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_sec_r <= '0;
      win_cnt_r <= '0;
    end else if (req.upd) begin
      win_sec_r <= req.sec;
      win_cnt_r <= win_cnt_nxt;
    end
  end

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && req.upd |=> win_cnt_r != '0)
    else $error("window count zero after a counted request");

  a_sec_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && req.upd |=> win_sec_r == $past(req.sec))
    else $error("window second does not follow the counted request");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && !req.upd |=> $stable(win_cnt_r) && $stable(win_sec_r))
    else $error("window state changed without a counted request");

endmodule

`default_nettype wire

/* rtl/ntp_request_responder.sv */
// Top level of the NTP request responder: config registers, request pipeline, reply build.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------------
//   in       | in_valid / in_stall  | length, first byte, client ts, tick, rx, tx
//   out      | out_valid / out_stall| action, header, dispersion, ref id, 4 stamps
//   cfg      | cfg_wr_en            | cfg_index, cfg_wdata (write only)
//
// One request per cycle sustained while out_stall is low; each request passes stages 1,
// 2 and 3, then the reply register. The depth is set by the last-sync conversion:
// reciprocal multiply, remainder recovery and fraction multiply, each behind a register.
// Synchronous reset clears the valid bits and the rate window and loads the config
// registers with their reset values.
// out_stall holds the reply and each full stage behind it up to the first empty one;
// in_stall rises only when all stages are full.
`default_nettype none

module ntp_request_responder (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // request channel
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [15:0]                        in_packet_length,
  input  wire logic [7:0]                         in_first_byte,
  input  wire logic [63:0]                        in_client_timestamp,
  input  wire logic [31:0]                        in_tick_ms,
  input  wire logic [31:0]                        in_rx_seconds,
  input  wire logic [19:0]                        in_rx_micros,
  input  wire logic [31:0]                        in_tx_seconds,
  input  wire logic [19:0]                        in_tx_micros,
  // reply channel
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic [2:0]                              out_action,
  output logic [31:0]                             out_header_word,
  output logic [31:0]                             out_dispersion_word,
  output logic [31:0]                             out_reference_id,
  output logic [63:0]                             out_reference_time,
  output logic [63:0]                             out_origin_time,
  output logic [63:0]                             out_receive_time,
  output logic [63:0]                             out_transmit_time,
  // configuration
  input  wire logic                               cfg_wr_en,
  input  wire logic [ntpr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ntpr_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import ntpr_pkg::*;

  // Configuration registers
  logic [3:0]  stratum_r;
  logic [15:0] root_disp_r;
  logic [1:0]  time_source_r;
  logic [47:0] ref_epoch_r;
  logic [15:0] rate_limit_r;

  // Pipeline control
  logic v1_r, v2_r, v3_r, out_valid_r;
  logic en1, en2, en3, en_out;

  // Stage 1 payload
  action_t     s1_act_r;
  logic [2:0]  s1_vn_r;
  logic [WIN_SEC_W-1:0] s1_sec_r;
  logic [63:0] s1_client_r;
  logic [63:0] s1_rx_r;
  logic [63:0] s1_tx_r;
  logic [22:0] s1_disp_r;

  // Stage 2 and 3 payload
  action_t     s2_act_r, s3_act_r;
  logic [2:0]  s2_vn_r, s3_vn_r;
  logic [63:0] s2_client_r, s3_client_r;
  logic [63:0] s2_rx_r, s3_rx_r;
  logic [63:0] s2_tx_r, s3_tx_r;
  logic [22:0] s2_disp_r, s3_disp_r;

  // Stage 1 input logic
  action_t     s1_act_nxt;
  logic [2:0]  vn_raw;
  logic [2:0]  s1_vn_nxt;
  logic [60:0] tick_prod;
  logic [66:0] rx_prod;
  logic [66:0] tx_prod;
  logic [45:0] disp_prod;

  // Stage 2 logic
  win_req_t    win_req;
  logic        win_over;
  action_t     s2_act_nxt;

  // Reply build
  logic [63:0] epoch_ntp;
  logic [31:0] refid_nxt;
  logic [2:0]  out_action_nxt;
  logic [31:0] out_header_nxt;
  logic [31:0] out_disp_nxt;
  logic [31:0] out_refid_nxt;
  logic [63:0] out_ref_nxt;
  logic [63:0] out_origin_nxt;
  logic [63:0] out_receive_nxt;
  logic [63:0] out_transmit_nxt;

  // Write configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stratum_r     <= '0;
      root_disp_r   <= '0;
      time_source_r <= '0;
      ref_epoch_r   <= '0;
      rate_limit_r  <= RATE_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_STRATUM:     stratum_r     <= cfg_wdata[3:0];
        CFG_ROOT_DISP:   root_disp_r   <= cfg_wdata[15:0];
        CFG_TIME_SOURCE: time_source_r <= cfg_wdata[1:0];
        CFG_REF_EPOCH:   ref_epoch_r   <= cfg_wdata[47:0];
        CFG_RATE_LIMIT:  rate_limit_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Advance a stage when it is empty or the one after it moves
  assign en_out   = !out_valid_r || !out_stall;
  assign en3      = !v3_r || en_out;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_stall = !en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1)    v1_r        <= in_valid;
      if (en2)    v2_r        <= v1_r;
      if (en3)    v3_r        <= v2_r;
      if (en_out) out_valid_r <= v3_r;
    end
  end

  // Drop checks, in order: length, sync, mode
  always_comb begin
    if (in_packet_length < MIN_REQ_LEN) begin
      s1_act_nxt = ACT_DROP_SHORT;
    end else if (stratum_r == 4'd0) begin
      s1_act_nxt = ACT_DROP_UNSYNC;
    end else if (in_first_byte[2:0] != MODE_CLIENT) begin
      s1_act_nxt = ACT_DROP_MODE;
    end else begin
      s1_act_nxt = ACT_SERVED;
    end
  end

  // Clamp the echoed version to 3..4
  assign vn_raw    = in_first_byte[5:3];
  assign s1_vn_nxt = (vn_raw < VN_MIN) ? VN_MIN : ((vn_raw > VN_MAX) ? VN_MAX : vn_raw);

  // Constant-divisor conversions by reciprocal multiply
  assign tick_prod = 61'(in_tick_ms)   * 61'(TICK_RECIP);
  assign rx_prod   = 67'(in_rx_micros) * 67'(MICRO_RECIP);
  assign tx_prod   = 67'(in_tx_micros) * 67'(MICRO_RECIP);
  assign disp_prod = 46'(root_disp_r)  * 46'(DISP_RECIP);

  // Stage 1: capture request and its converted fields
  always_ff @(posedge clk) begin
    if (en1) begin
      s1_act_r    <= s1_act_nxt;
      s1_vn_r     <= s1_vn_nxt;
      s1_sec_r    <= tick_prod[60:38];
      s1_client_r <= in_client_timestamp;
      s1_rx_r     <= {in_rx_seconds + NTP_UNIX_OFFSET, rx_prod[65:34]};
      s1_tx_r     <= {in_tx_seconds + NTP_UNIX_OFFSET, tx_prod[65:34]};
      s1_disp_r   <= disp_prod[45:23];
    end
  end

  // Count a passing request as it leaves stage 1
  assign win_req.upd = v1_r && en2 && (s1_act_r == ACT_SERVED);
  assign win_req.sec = s1_sec_r;

  ntpr_rate_window u_window (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (win_req),
    .rate_limit (rate_limit_r),
    .over       (win_over)
  );

  assign s2_act_nxt = ((s1_act_r == ACT_SERVED) && win_over) ? ACT_RATE_KISS : s1_act_r;

  // Stages 2 and 3: carry the request alongside the last-sync conversion
  always_ff @(posedge clk) begin
    if (en2) begin
      s2_act_r    <= s2_act_nxt;
      s2_vn_r     <= s1_vn_r;
      s2_client_r <= s1_client_r;
      s2_rx_r     <= s1_rx_r;
      s2_tx_r     <= s1_tx_r;
      s2_disp_r   <= s1_disp_r;
    end
    if (en3) begin
      s3_act_r    <= s2_act_r;
      s3_vn_r     <= s2_vn_r;
      s3_client_r <= s2_client_r;
      s3_rx_r     <= s2_rx_r;
      s3_tx_r     <= s2_tx_r;
      s3_disp_r   <= s2_disp_r;
    end
  end

  ntpr_epoch_conv u_epoch (
    .clk      (clk),
    .epoch_ms (ref_epoch_r),
    .ref_ntp  (epoch_ntp)
  );

  // Pick reference id from the time source
  always_comb begin
    case (time_source_r)
      SRC_NETWORK:  refid_nxt = REFID_DOT_GPS;
      SRC_CELLULAR: refid_nxt = REFID_DOT_LOC;
      default:      refid_nxt = REFID_GPS_DOT;
    endcase
  end

  // Build reply words; dropped requests give zero words
  always_comb begin
    out_action_nxt   = s3_act_r;
    out_header_nxt   = '0;
    out_disp_nxt     = '0;
    out_refid_nxt    = '0;
    out_ref_nxt      = '0;
    out_origin_nxt   = '0;
    out_receive_nxt  = '0;
    out_transmit_nxt = '0;
    case (s3_act_r)
      ACT_SERVED: begin
        out_header_nxt   = {LEAP_NONE, s3_vn_r, MODE_SERVER, 4'd0, stratum_r,
                            POLL_BYTE, PRECISION_BYTE};
        out_disp_nxt     = {9'd0, s3_disp_r};
        out_refid_nxt    = refid_nxt;
        out_ref_nxt      = (ref_epoch_r != '0) ? epoch_ntp : s3_rx_r;
        out_origin_nxt   = s3_client_r;
        out_receive_nxt  = s3_rx_r;
        out_transmit_nxt = s3_tx_r;
      end
      ACT_RATE_KISS: begin
        out_header_nxt   = {LEAP_ALARM, s3_vn_r, MODE_SERVER, 8'd0,
                            POLL_BYTE, PRECISION_BYTE};
        out_refid_nxt    = REFID_RATE;
        out_origin_nxt   = s3_client_r;
        out_receive_nxt  = s3_client_r;
        out_transmit_nxt = s3_client_r;
      end
      default: ;
    endcase
  end

  // Reply register: hold while stalled
  always_ff @(posedge clk) begin
    if (en_out) begin
      out_action          <= out_action_nxt;
      out_header_word     <= out_header_nxt;
      out_dispersion_word <= out_disp_nxt;
      out_reference_id    <= out_refid_nxt;
      out_reference_time  <= out_ref_nxt;
      out_origin_time     <= out_origin_nxt;
      out_receive_time    <= out_receive_nxt;
      out_transmit_time   <= out_transmit_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> v1_r && v2_r && v3_r && out_valid_r && out_stall)
    else $error("request stalled with an empty stage");

  a_kiss_words: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_action == ACT_RATE_KISS) |->
      (out_reference_id == REFID_RATE) && (out_receive_time == out_origin_time) &&
      (out_transmit_time == out_origin_time) && (out_reference_time == '0))
    else $error("rate kiss reply words inconsistent");

  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ((out_action == ACT_DROP_SHORT) || (out_action == ACT_DROP_UNSYNC) ||
                    (out_action == ACT_DROP_MODE)) |->
      (out_header_word == '0) && (out_origin_time == '0) && (out_reference_id == '0))
    else $error("dropped request carries reply words");

endmodule

`default_nettype wire

/* verif/tb.sv */
// Self-checking testbench for ntp_request_responder: clocked driver, monitor and predictor.
module tb;
  import ntpr_pkg::*;

  // Reply constants, kept apart from the package
  localparam logic [15:0] REQ_MIN_LEN     = 16'd48;
  localparam logic [2:0]  MODE_REQ        = 3'd3;
  localparam logic [2:0]  MODE_REPLY      = 3'd4;
  localparam logic [1:0]  LI_OK           = 2'b00;
  localparam logic [1:0]  LI_UNSYNC       = 2'b11;
  localparam logic [2:0]  VER_LO          = 3'd3;
  localparam logic [2:0]  VER_HI          = 3'd4;
  localparam logic [7:0]  POLL_EXP        = 8'd6;
  localparam logic [7:0]  PRECISION_EXP   = 8'hEC;
  localparam logic [31:0] UNIX_EPOCH_NTP  = 32'd2208988800;
  localparam logic [31:0] ID_GPS_DOT      = "GPS.";
  localparam logic [31:0] ID_DOT_GPS      = ".GPS";
  localparam logic [31:0] ID_DOT_LOC      = ".LOC";
  localparam logic [31:0] ID_RATE         = "RATE";
  localparam logic [15:0] WIN_COUNT_TOP   = 16'hFFFF;
  localparam logic [1:0]  SRC_UNUSED      = 2'd3;
  localparam int          SETTLE_CYCLES   = 8;
  localparam int          HOLD_CYCLES     = 64;
  localparam int          CALM_REQUESTS   = 100;

  typedef struct packed {
    logic [15:0] plen;
    logic [7:0]  fbyte;
    logic [63:0] client_ts;
    logic [31:0] tick;
    logic [31:0] rx_s;
    logic [19:0] rx_us;
    logic [31:0] tx_s;
    logic [19:0] tx_us;
  } ntp_req_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] header;
    logic [31:0] disp;
    logic [31:0] ref_id;
    logic [63:0] ref_ts;
    logic [63:0] orig_ts;
    logic [63:0] rx_ts;
    logic [63:0] tx_ts;
  } ntp_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_packet_length = '0;
  logic [7:0]  in_first_byte = '0;
  logic [63:0] in_client_timestamp = '0;
  logic [31:0] in_tick_ms = '0;
  logic [31:0] in_rx_seconds = '0;
  logic [19:0] in_rx_micros = '0;
  logic [31:0] in_tx_seconds = '0;
  logic [19:0] in_tx_micros = '0;

  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_action;
  logic [31:0] out_header_word;
  logic [31:0] out_dispersion_word;
  logic [31:0] out_reference_id;
  logic [63:0] out_reference_time;
  logic [63:0] out_origin_time;
  logic [63:0] out_receive_time;
  logic [63:0] out_transmit_time;

  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Register and rate-window copies
  logic [3:0]  m_stratum = 4'd0;
  logic [15:0] m_disp_ms = 16'd0;
  logic [1:0]  m_source = 2'd0;
  logic [47:0] m_epoch_ms = 48'd0;
  logic [15:0] m_rate_limit = 16'd20;
  logic [22:0] win_sec = '0;
  logic [15:0] win_cnt = '0;

  ntp_req_t   pending_reqs[$];
  ntp_reply_t expected_replies[$];
  ntp_req_t   offered;
  ntp_reply_t oldest;

  int issued = 0;
  int accepted = 0;
  int errors = 0;
  int n_served = 0;
  int n_kiss = 0;
  int n_dropped = 0;
  int n_settings = 0;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  logic calm = 1'b0;
  logic [31:0] tick_now = 32'd0;

  ntp_request_responder dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_packet_length    (in_packet_length),
    .in_first_byte       (in_first_byte),
    .in_client_timestamp (in_client_timestamp),
    .in_tick_ms          (in_tick_ms),
    .in_rx_seconds       (in_rx_seconds),
    .in_rx_micros        (in_rx_micros),
    .in_tx_seconds       (in_tx_seconds),
    .in_tx_micros        (in_tx_micros),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_action          (out_action),
    .out_header_word     (out_header_word),
    .out_dispersion_word (out_dispersion_word),
    .out_reference_id    (out_reference_id),
    .out_reference_time  (out_reference_time),
    .out_origin_time     (out_origin_time),
    .out_receive_time    (out_receive_time),
    .out_transmit_time   (out_transmit_time),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  always #2 clk = ~clk;

  // Unix seconds plus a fraction num/den to an NTP timestamp
  function automatic logic [63:0] unix_to_ntp(input logic [31:0] secs, input logic [63:0] num,
                                              input logic [63:0] den);
    logic [31:0] s;
    logic [63:0] f;
    s = secs + UNIX_EPOCH_NTP;
    f = (num << 32) / den;
    return {s, f[31:0]};
  endfunction

  // Work out the reply to one accepted request and advance the rate window
  task automatic predict_reply(input ntp_req_t r, output ntp_reply_t e);
    logic [22:0] sec;
    logic [2:0]  vn;
    logic        over;
    logic [63:0] rx_ntp;
    e = '0;
    if (r.plen < REQ_MIN_LEN) begin
      e.action = ACT_DROP_SHORT;
    end else if (m_stratum == 4'd0) begin
      e.action = ACT_DROP_UNSYNC;
    end else if (r.fbyte[2:0] != MODE_REQ) begin
      e.action = ACT_DROP_MODE;
    end else begin
      sec = 23'(r.tick / 32'd1000);
      if (sec != win_sec) begin
        win_sec = sec;
        win_cnt = '0;
      end
      if (win_cnt != WIN_COUNT_TOP) win_cnt = win_cnt + 16'd1;
      over = win_cnt > m_rate_limit;
      vn = r.fbyte[5:3];
      if (vn < VER_LO) vn = VER_LO;
      if (vn > VER_HI) vn = VER_HI;
      e.orig_ts = r.client_ts;
      if (over) begin
        e.action = ACT_RATE_KISS;
        e.header = {LI_UNSYNC, vn, MODE_REPLY, 8'd0, POLL_EXP, PRECISION_EXP};
        e.ref_id = ID_RATE;
        e.rx_ts  = r.client_ts;
        e.tx_ts  = r.client_ts;
      end else begin
        rx_ntp   = unix_to_ntp(r.rx_s, 64'(r.rx_us), 64'd1000000);
        e.action = ACT_SERVED;
        e.header = {LI_OK, vn, MODE_REPLY, 4'd0, m_stratum, POLL_EXP, PRECISION_EXP};
        e.disp   = 32'((64'(m_disp_ms) * 64'd65536) / 64'd1000);
        case (m_source)
          SRC_NETWORK:  e.ref_id = ID_DOT_GPS;
          SRC_CELLULAR: e.ref_id = ID_DOT_LOC;
          default:      e.ref_id = ID_GPS_DOT;
        endcase
        if (m_epoch_ms != 48'd0)
          e.ref_ts = unix_to_ntp(32'(m_epoch_ms / 48'd1000), 64'(m_epoch_ms % 48'd1000),
                                 64'd1000);
        else
          e.ref_ts = rx_ntp;
        e.rx_ts = rx_ntp;
        e.tx_ts = unix_to_ntp(r.tx_s, 64'(r.tx_us), 64'd1000000);
      end
    end
    case (e.action)
      ACT_SERVED:    n_served++;
      ACT_RATE_KISS: n_kiss++;
      default:       n_dropped++;
    endcase
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Request driver: present the next pending request, hold it while stalled
  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      predict_reply(offered, oldest);
      expected_replies.push_back(oldest);
      accepted++;
    end
    if (!in_valid || !in_stall) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(0, 99) >= 13)) begin
        offered = pending_reqs.pop_front();
        in_valid            <= 1'b1;
        in_packet_length    <= offered.plen;
        in_first_byte       <= offered.fbyte;
        in_client_timestamp <= offered.client_ts;
        in_tick_ms          <= offered.tick;
        in_rx_seconds       <= offered.rx_s;
        in_rx_micros        <= offered.rx_us;
        in_tx_seconds       <= offered.tx_s;
        in_tx_micros        <= offered.tx_us;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Reply monitor: compare each reply with the oldest prediction, then pick the next stall
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected reply: expected none, actual action %0d", $time, out_action);
      end else begin
        oldest = expected_replies.pop_front();
        check_field("action", 64'(oldest.action), 64'(out_action));
        check_field("header_word", 64'(oldest.header), 64'(out_header_word));
        check_field("dispersion_word", 64'(oldest.disp), 64'(out_dispersion_word));
        check_field("reference_id", 64'(oldest.ref_id), 64'(out_reference_id));
        check_field("reference_time", oldest.ref_ts, out_reference_time);
        check_field("origin_time", oldest.orig_ts, out_origin_time);
        check_field("receive_time", oldest.rx_ts, out_receive_time);
        check_field("transmit_time", oldest.tx_ts, out_transmit_time);
      end
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (holds_done < hold_requests) begin
      holds_done++;
      hold_left = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 13);
    end
  end

  task automatic write_reg(input cfg_idx_t idx, input logic [47:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_STRATUM:     m_stratum    = val[3:0];
      CFG_ROOT_DISP:   m_disp_ms    = val[15:0];
      CFG_TIME_SOURCE: m_source     = val[1:0];
      CFG_REF_EPOCH:   m_epoch_ms   = val[47:0];
      CFG_RATE_LIMIT:  m_rate_limit = val[15:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_config(input logic [3:0] stratum, input logic [15:0] disp_ms,
                            input logic [1:0] source, input logic [47:0] epoch_ms,
                            input logic [15:0] rate_limit);
    write_reg(CFG_STRATUM, 48'(stratum));
    write_reg(CFG_ROOT_DISP, 48'(disp_ms));
    write_reg(CFG_TIME_SOURCE, 48'(source));
    write_reg(CFG_REF_EPOCH, epoch_ms);
    write_reg(CFG_RATE_LIMIT, 48'(rate_limit));
    n_settings++;
  endtask

  task automatic offer(input ntp_req_t r);
    pending_reqs.push_back(r);
    issued++;
  endtask

  // Wait until every request is accepted and answered, then let the pipeline settle
  task automatic drain();
    do @(posedge clk); while (accepted != issued || expected_replies.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic ntp_req_t mk(input logic [15:0] plen, input logic [7:0] fbyte,
                                  input logic [63:0] client_ts, input logic [31:0] tick,
                                  input logic [31:0] rx_s, input logic [19:0] rx_us,
                                  input logic [31:0] tx_s, input logic [19:0] tx_us);
    ntp_req_t r;
    r = '{plen, fbyte, client_ts, tick, rx_s, rx_us, tx_s, tx_us};
    return r;
  endfunction

  // Mostly in range, sometimes any 20-bit value
  function automatic logic [19:0] rand_micros();
    if ($urandom_range(0, 9) == 0) return 20'($urandom);
    return 20'($urandom_range(0, 999999));
  endfunction

  // Advance the arrival tick slowly so windows fill, with jumps and wrap-around
  function automatic logic [31:0] step_tick();
    int k;
    k = $urandom_range(0, 99);
    if (k < 5) tick_now = $urandom;
    else if (k < 8) tick_now = 32'hFFFF_FC00 + 32'($urandom_range(0, 1023));
    else tick_now = tick_now + 32'($urandom_range(0, 40));
    return tick_now;
  endfunction

  // Well-formed client request with random content
  function automatic ntp_req_t client_request(input logic [31:0] tick);
    logic [15:0] plen;
    if ($urandom_range(0, 3) == 0) plen = 16'($urandom_range(48, 65535));
    else plen = REQ_MIN_LEN + 16'($urandom_range(0, 20));
    return mk(plen, {2'($urandom), 3'($urandom), MODE_REQ}, {$urandom, $urandom}, tick,
              $urandom, rand_micros(), $urandom, rand_micros());
  endfunction

  // Mix of well-formed, broken and fully random requests
  function automatic ntp_req_t next_request();
    ntp_req_t r;
    int k;
    int m;
    r = client_request(step_tick());
    k = $urandom_range(0, 99);
    if (k < 6) begin
      r.plen = 16'($urandom_range(0, 47));
    end else if (k < 12) begin
      m = $urandom_range(0, 6);
      if (m >= 3) m++;
      r.fbyte[2:0] = 3'(m);
    end else if (k < 20) begin
      r.plen  = 16'($urandom);
      r.fbyte = 8'($urandom);
      r.tick  = $urandom;
      r.rx_us = 20'($urandom);
      r.tx_us = 20'($urandom);
    end
    return r;
  endfunction

  initial begin
    int n;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: short length wins over unsynced, everything else unsynced
    offer(mk(16'd0, 8'h1B, '1, 32'd0, 32'd0, 20'd0, 32'd0, 20'd0));
    offer(mk(16'd47, 8'h1B, 64'd5, 32'd10, 32'd1, 20'd1, 32'd1, 20'd1));
    offer(mk(REQ_MIN_LEN, 8'h1B, 64'd6, 32'd20, 32'd2, 20'd2, 32'd2, 20'd2));
    offer(mk(16'hFFFF, 8'hE3, '1, '1, '1, 20'hFFFFF, '1, 20'hFFFFF));
    drain();

    // Every mode, each in its own window
    set_config(4'd1, 16'd0, SRC_OTHER, 48'd0, 16'd2);
    for (int m = 0; m < 8; m++)
      offer(mk(REQ_MIN_LEN, {LI_OK, 3'd4, 3'(m)}, {$urandom, $urandom}, 32'(1000 * (m + 1)),
               $urandom, 20'd500000, $urandom, 20'd250000));
    // Version clamp at both ends, all leap codes
    offer(mk(REQ_MIN_LEN, {2'b01, 3'd0, MODE_REQ}, '0, 32'd20000, '0, 20'd0, '0, 20'd0));
    offer(mk(REQ_MIN_LEN, {2'b10, 3'd2, MODE_REQ}, '1, 32'd21000, '1, 20'd999999,
             '1, 20'd999999));
    offer(mk(REQ_MIN_LEN, {2'b11, 3'd5, MODE_REQ}, 64'h0123_4567_89AB_CDEF, 32'd22000,
             32'hFFFF_FFFF, 20'hFFFFF, 32'd0, 20'hFFFFF));
    offer(mk(16'hFFFF, {2'b00, 3'd7, MODE_REQ}, 64'h8000_0000_0000_0001, 32'd23000,
             32'h7FFF_FFFF, 20'd1, 32'h8000_0000, 20'd999999));
    // Three in the top window: the third goes over a limit of two
    offer(mk(REQ_MIN_LEN, 8'h23, '1, 32'hFFFF_FFFF, '1, 20'd999999, '1, 20'hFFFFF));
    offer(mk(REQ_MIN_LEN, 8'h1B, '0, 32'd4294967000, '0, 20'hFFFFF, '0, 20'd0));
    offer(mk(REQ_MIN_LEN, 8'h3B, 64'hDEAD_BEEF_0000_FFFF, 32'd4294967295, 32'd1,
             20'd1, 32'd1, 20'd1));
    drain();

    // Top stratum and dispersion, unused source code, largest last-sync time
    set_config(4'd15, 16'hFFFF, SRC_UNUSED, 48'hFFFF_FFFF_FFFF, 16'hFFFF);
    offer(mk(REQ_MIN_LEN, 8'h23, {$urandom, $urandom}, 32'd0, $urandom, 20'd123456,
             $urandom, 20'd654321));
    drain();
    // Zero limit: every request gets the kiss
    set_config(4'd15, 16'hFFFF, SRC_NETWORK, 48'd999, 16'd0);
    offer(mk(REQ_MIN_LEN, 8'h23, {$urandom, $urandom}, 32'd5000, $urandom, 20'd1,
             $urandom, 20'd2));
    drain();
    set_config(4'd7, 16'd1, SRC_CELLULAR, 48'd1000, 16'd20);
    offer(mk(REQ_MIN_LEN, 8'h1B, {$urandom, $urandom}, 32'd6000, $urandom, 20'd7,
             $urandom, 20'd8));
    drain();

    // Random phases over a spread of settings
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: set_config(4'd1, 16'd0, SRC_OTHER, 48'd0, 16'd20);
        1: set_config(4'd15, 16'hFFFF, SRC_NETWORK, 48'hFFFF_FFFF_FFFF, 16'd0);
        2: set_config(4'($urandom_range(1, 15)), 16'($urandom), SRC_CELLULAR,
                      {16'($urandom), $urandom}, 16'd3);
        3: set_config(4'd0, 16'($urandom), SRC_OTHER, 48'd0, 16'd5);
        4: set_config(4'($urandom_range(1, 15)), 16'($urandom), SRC_UNUSED,
                      {16'($urandom), $urandom}, 16'hFFFF);
        5: set_config(4'($urandom_range(1, 15)), 16'($urandom), 2'($urandom),
                      {16'($urandom), $urandom}, 16'($urandom_range(0, 40)));
        default: set_config(4'($urandom_range(1, 15)), 16'($urandom), 2'($urandom),
                            48'd0, 16'd1);
      endcase
      n = (ph == 3) ? 60 : 280;
      for (int i = 0; i < n / 2; i++) offer(next_request());
      // Stall the replies long enough to back up the pipeline, then let it all drain
      hold_requests <= hold_requests + 1;
      drain();
      for (int i = n / 2; i < n; i++) offer(next_request());
      drain();
    end

    // One long window with no idling: the count runs past the limit and keeps kissing
    set_config(4'd2, 16'd1000, SRC_NETWORK, 48'd0, 16'd40);
    calm <= 1'b1;
    for (int i = 0; i < CALM_REQUESTS; i++)
      offer(client_request(32'd7000000 + 32'($urandom_range(0, 999))));
    drain();
    calm <= 1'b0;

    $display("Run covered %0d requests over %0d register settings:", issued, n_settings);
    $display("  %0d served, %0d rate kisses, %0d dropped", n_served, n_kiss, n_dropped);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Run limit
  initial begin
    #200000;
    $display("Timed out with %0d replies outstanding", expected_replies.size());
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* ntp_request_responder.f */
rtl/ntpr_pkg.sv
rtl/ntpr_epoch_conv.sv
rtl/ntpr_rate_window.sv
rtl/ntp_request_responder.sv
verif/tb.sv
